>>> src/indexed_deque_store_top_macros.svh
// ----------------------------------------------------------------------------
// indexed_deque_store_top_macros
// Assertion macros used by the deque store top module.
// ----------------------------------------------------------------------------
`ifndef INDEXED_DEQUE_STORE_TOP_MACROS_SVH
`define INDEXED_DEQUE_STORE_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define IDQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque store assertion failed");

// next-cycle implication, disabled while in reset
`define IDQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque store assertion failed");

`endif

>>> src/idq_pkg.sv
// ----------------------------------------------------------------------------
// idq_pkg
// Operation codes, status codes and control types of the deque store.
// ----------------------------------------------------------------------------
package idq_pkg;

	localparam int POS_W = 4;
	localparam int OP_W  = 3;
	localparam int STAT_W = 2;

	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ       = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

	typedef enum logic {
		S_IDLE,
		S_RESP
	} state_t;

	// which response word the RAM read data feeds
	typedef enum logic [1:0] {
		SEL_NONE,
		SEL_READ,
		SEL_FRONT,
		SEL_BACK
	} sel_t;

endpackage

>>> src/idq_in_if.sv
// ----------------------------------------------------------------------------
// idq_in_if
// Request channel of the deque store: operation, word and read position.
// ----------------------------------------------------------------------------
interface idq_in_if #(
	parameter int WORD_WIDTH = 32
);
	logic                               valid;
	logic                               ready;
	logic [idq_pkg::OP_W-1:0]           operation;
	logic signed [WORD_WIDTH-1:0]       word_in;
	logic [idq_pkg::POS_W-1:0]          position;

	modport source (output valid, output operation, output word_in, output position,
		input ready);
	modport sink (input valid, input operation, input word_in, input position,
		output ready);
endinterface

>>> src/idq_out_if.sv
// ----------------------------------------------------------------------------
// idq_out_if
// Response channel of the deque store: status, read word, length and ends.
// ----------------------------------------------------------------------------
interface idq_out_if #(
	parameter int WORD_WIDTH = 32,
	parameter int CNT_W      = 5
);
	logic                           valid;
	logic                           ready;
	logic [idq_pkg::STAT_W-1:0]     status;
	logic signed [WORD_WIDTH-1:0]   word_read;
	logic [CNT_W-1:0]               count_after;
	logic signed [WORD_WIDTH-1:0]   front_word;
	logic signed [WORD_WIDTH-1:0]   back_word;

	modport source (output valid, output status, output word_read, output count_after,
		output front_word, output back_word, input ready);
	modport sink (input valid, input status, input word_read, input count_after,
		input front_word, input back_word, output ready);
endinterface

>>> src/idq_ram.sv
// ----------------------------------------------------------------------------
// idq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module idq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

>>> src/indexed_deque_store_top.sv
// ----------------------------------------------------------------------------
// indexed_deque_store_top
// Bounded deque of signed words in a circular RAM, with indexed read.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transfer: push back, push front, pop back,
//   pop front or read at a position from the front. rsp returns one result
//   per request: status, word read, length, front word and back word after
//   the operation.
//   Latency: the result is valid the cycle after the request transfer.
//   The RAM has one read port with registered read data; the request
//   cycle does the write and the read, the next cycle presents the
//   result. Only one of word read, new front or new back ever needs the
//   RAM; the ends are kept in registers otherwise.
//   A new request is taken only once the result has transferred, so a
//   stalled rsp holds the result and keeps req.ready low.
//   Reset: the deque is empty, head at entry 0. RAM contents are not
//   cleared; only written entries are ever read. No clearing pass.
//   Unused operation codes change nothing and report ok.
// ----------------------------------------------------------------------------
`include "indexed_deque_store_top_macros.svh"

module indexed_deque_store_top #(
	parameter int DEPTH      = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	idq_in_if.sink    req,
	idq_out_if.source rsp
);
	import idq_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

	state_t state_q, state_d;

	logic [AW-1:0]         front_q;
	logic [CW-1:0]         count_q;
	logic [WORD_WIDTH-1:0] front_word_q, back_word_q;
	logic [STAT_W-1:0]     status_q;
	sel_t                  sel_q;

	logic                  acc, done;
	logic                  wr_en, rd_en;
	logic [AW-1:0]         wr_addr, rd_addr;
	logic [WORD_WIDTH-1:0] rd_data;

	logic [AW-1:0]         front_d;
	logic [CW-1:0]         count_d;
	logic [WORD_WIDTH-1:0] front_word_d, back_word_d;
	logic [STAT_W-1:0]     status_d;
	sel_t                  sel_d;

	logic [CMPW-1:0]       pos_ext, cnt_ext;
	logic [CW-1:0]         cnt_m2;
	logic [AW-1:0]         front_m1;
	logic                  empty, full;

	// base + off modulo DEPTH, both operands below DEPTH
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[AW-1:0];
	endfunction

	idq_ram #(
		.WIDTH(WORD_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (req.word_in),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign acc  = req.valid && req.ready;
	assign done = rsp.valid && rsp.ready;

	assign empty    = (count_q == '0);
	assign full     = (count_q == FULL_C);
	assign pos_ext  = CMPW'(req.position);
	assign cnt_ext  = CMPW'(count_q);
	assign cnt_m2   = count_q - CW'(2);
	assign front_m1 = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);

	// operation decode and RAM access for the request cycle
	always_comb begin
		wr_en        = 1'b0;
		rd_en        = 1'b0;
		wr_addr      = wrap_add(front_q, count_q[AW-1:0]);
		rd_addr      = wrap_add(front_q, pos_ext[AW-1:0]);
		front_d      = front_q;
		count_d      = count_q;
		front_word_d = front_word_q;
		back_word_d  = back_word_q;
		status_d     = STAT_OK;
		sel_d        = SEL_NONE;
		unique case (req.operation)
			OP_PUSH_BACK: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					wr_en       = acc;
					count_d     = count_q + CW'(1);
					back_word_d = req.word_in;
					if (empty) begin
						front_word_d = req.word_in;
					end
				end
			end
			OP_PUSH_FRONT: begin
				wr_addr = front_m1;
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					wr_en        = acc;
					front_d      = front_m1;
					count_d      = count_q + CW'(1);
					front_word_d = req.word_in;
					if (empty) begin
						back_word_d = req.word_in;
					end
				end
			end
			OP_POP_BACK: begin
				rd_addr = wrap_add(front_q, cnt_m2[AW-1:0]);
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					count_d = count_q - CW'(1);
					if (count_q == CW'(1)) begin
						front_word_d = '0;
						back_word_d  = '0;
					end else begin
						rd_en = acc;
						sel_d = SEL_BACK;
					end
				end
			end
			OP_POP_FRONT: begin
				rd_addr = wrap_add(front_q, AW'(1));
				if (empty) begin
					status_d = STAT_EMPTY;
				end else begin
					front_d = wrap_add(front_q, AW'(1));
					count_d = count_q - CW'(1);
					if (count_q == CW'(1)) begin
						front_word_d = '0;
						back_word_d  = '0;
					end else begin
						rd_en = acc;
						sel_d = SEL_FRONT;
					end
				end
			end
			OP_READ: begin
				if (pos_ext >= cnt_ext) begin
					status_d = STAT_RANGE;
				end else begin
					rd_en = acc;
					sel_d = SEL_READ;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (done) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready       = (state_q == S_IDLE);
		rsp.valid       = (state_q == S_RESP);
		rsp.status      = status_q;
		rsp.count_after = count_q;
		rsp.word_read   = (sel_q == SEL_READ)  ? rd_data : '0;
		rsp.front_word  = (sel_q == SEL_FRONT) ? rd_data : front_word_q;
		rsp.back_word   = (sel_q == SEL_BACK)  ? rd_data : back_word_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			front_q      <= '0;
			count_q      <= '0;
			front_word_q <= '0;
			back_word_q  <= '0;
			status_q     <= STAT_OK;
			sel_q        <= SEL_NONE;
		end else begin
			state_q <= state_d;
			if (acc) begin
				front_q      <= front_d;
				count_q      <= count_d;
				front_word_q <= front_word_d;
				back_word_q  <= back_word_d;
				status_q     <= status_d;
				sel_q        <= sel_d;
			end else if (done) begin
				// fold the end word fetched from RAM back into its register
				if (sel_q == SEL_FRONT) begin
					front_word_q <= rd_data;
				end
				if (sel_q == SEL_BACK) begin
					back_word_q <= rd_data;
				end
				sel_q <= SEL_NONE;
			end
		end
	end

	`IDQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_C)
	`IDQ_ASSERT_NXT(a_rsp_follows, clk, arst_n, acc, rsp.valid)
	`IDQ_ASSERT_IMP(a_empty_ends_zero, clk, arst_n, rsp.valid && (rsp.count_after == '0),
		(rsp.front_word == '0) && (rsp.back_word == '0))
	`IDQ_ASSERT_NXT(a_pop_count, clk, arst_n,
		acc && !empty && ((req.operation == OP_POP_BACK) || (req.operation == OP_POP_FRONT)),
		count_q == $past(count_q) - CW'(1))

endmodule
